// ----- hdl/mlc_pkg.sv -----
package mlc_pkg;

    // Coordinate width of every window register, input field and result field
    localparam int COORD_BITS = 11;

    // Pieces emitted for one segment before the work is cut short
    localparam int MAX_RESULTS = 32;
    localparam int NCNT_BITS   = $clog2(MAX_RESULTS + 1);

    // Region outcode bits
    localparam logic [3:0] CODE_LEFT   = 4'h1;
    localparam logic [3:0] CODE_BOTTOM = 4'h2;
    localparam logic [3:0] CODE_RIGHT  = 4'h4;
    localparam logic [3:0] CODE_TOP    = 4'h8;

    // Configuration register indexes (byte address 4*index)
    localparam logic [1:0] REG_WINDOW_LEFT   = 2'd0;
    localparam logic [1:0] REG_WINDOW_RIGHT  = 2'd1;
    localparam logic [1:0] REG_WINDOW_BOTTOM = 2'd2;
    localparam logic [1:0] REG_WINDOW_TOP    = 2'd3;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [3:0]            t_code;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
    } t_seg;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_in_item;

    typedef struct packed {
        logic   visible;
        t_coord piece_ax;
        t_coord piece_ay;
        t_coord piece_bx;
        t_coord piece_by;
        logic   last;
    } t_out_item;

    // Region outcode of one point against the window
    function automatic t_code outcode(input t_coord x, input t_coord y,
                                      input t_coord left, input t_coord right,
                                      input t_coord bottom, input t_coord top);
        t_code c;
        c = '0;
        if (x < left)   c = c | CODE_LEFT;
        if (x > right)  c = c | CODE_RIGHT;
        if (y < bottom) c = c | CODE_BOTTOM;
        if (y > top)    c = c | CODE_TOP;
        return c;
    endfunction

endpackage

// ----- hdl/midpoint_line_clipper_core.sv -----
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+---------------------------------
// in       | input     | i_in_valid / o_in_stall   | i_in_data  (start_x..end_y)
// out      | output    | o_out_valid / i_out_stall | o_out_data (visible..last)
// apb      | input     | psel penable pwrite pready | paddr, pwdata, prdata (windows)
//
// A step that ends at the outcode test (reject or fully inside) passes ORDER to order the
// ends, CODEA and CODEB for the first and second end through the single outcode unit, then
// MID for the test. A step that subdivides goes on through CODEM and DECIDE: the midpoint
// pass and the decision. A visible piece passes EMIT, each dropped segment NEXT (which also
// pops a pending half), the closing result FINISH, and accepting a segment IDLE.
// Reset is synchronous and active low; it restores the full window and empties the block.
// The block takes a new segment only when idle; a stalled output holds the sequencer
// whenever a finished piece must move out and the output register is still full.
module midpoint_line_clipper_core #(
    parameter int STACK_DEPTH = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mlc_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mlc_pkg::t_out_item   o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int CB = mlc_pkg::COORD_BITS;
    localparam int NB = mlc_pkg::NCNT_BITS;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ORDER  = 4'd1;
    localparam logic [3:0] ST_CODEA  = 4'd2;
    localparam logic [3:0] ST_CODEB  = 4'd3;
    localparam logic [3:0] ST_MID    = 4'd4;
    localparam logic [3:0] ST_CODEM  = 4'd5;
    localparam logic [3:0] ST_DECIDE = 4'd6;
    localparam logic [3:0] ST_EMIT   = 4'd7;
    localparam logic [3:0] ST_NEXT   = 4'd8;
    localparam logic [3:0] ST_FINISH = 4'd9;

    logic [3:0]          r_state;
    logic [CW-1:0]       r_cnt;
    logic [NB-1:0]       r_n;
    logic                r_ov;
    logic                r_held_v;
    logic                r_done_after;
    mlc_pkg::t_coord     r_left, r_right, r_bottom, r_top;

    mlc_pkg::t_seg       r_seg;
    mlc_pkg::t_seg       r_pc;
    mlc_pkg::t_seg       r_held;
    mlc_pkg::t_code      r_c1, r_c2, r_cm;
    mlc_pkg::t_coord     r_tx, r_ty;
    mlc_pkg::t_out_item  r_out;
    mlc_pkg::t_seg       r_stack [STACK_DEPTH];

    logic                in_acc;
    logic                out_free;
    logic                out_load;
    logic                cfg_wr;
    mlc_pkg::t_coord     px, py;
    mlc_pkg::t_code      code_q;
    logic [CB:0]         sum_x, sum_y;
    logic                stop;
    logic                emit_dec;
    logic                push_dec;
    logic                push_en;
    logic                can_push;
    logic [CW-1:0]       pop_cnt;
    mlc_pkg::t_seg       seg_lo;
    mlc_pkg::t_seg       seg_hi;
    mlc_pkg::t_seg       swapped;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_ov || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign can_push = (r_cnt < CW'(STACK_DEPTH));
    assign pop_cnt  = r_cnt - CW'(1);

    // Load the output register with a finished piece or the closing result
    assign out_load = ((r_state == ST_EMIT) && r_held_v && out_free) ||
                      ((r_state == ST_FINISH) && out_free);

    // Select the point for the shared outcode unit
    always_comb begin
        case (r_state)
            ST_CODEA: begin
                px = r_seg.ax;
                py = r_seg.ay;
            end
            ST_CODEB: begin
                px = r_seg.bx;
                py = r_seg.by;
            end
            default: begin
                px = r_tx;
                py = r_ty;
            end
        endcase
    end

    assign code_q = mlc_pkg::outcode(px, py, r_left, r_right, r_bottom, r_top);

    // Midpoint adder
    assign sum_x = {1'b0, r_seg.ax} + {1'b0, r_seg.bx};
    assign sum_y = {1'b0, r_seg.ay} + {1'b0, r_seg.by};

    // Halves around the midpoint, and the swapped segment
    assign seg_lo  = '{ax: r_seg.ax, ay: r_seg.ay, bx: r_tx, by: r_ty};
    assign seg_hi  = '{ax: r_tx, ay: r_ty, bx: r_seg.bx, by: r_seg.by};
    assign swapped = '{ax: r_seg.bx, ay: r_seg.by, bx: r_seg.ax, by: r_seg.ay};

    // Step decision on the registered codes and midpoint
    always_comb begin
        stop     = ((r_tx == r_seg.ax) && (r_ty == r_seg.ay)) ||
                   ((r_tx == r_seg.bx) && (r_ty == r_seg.by));
        emit_dec = 1'b0;
        push_dec = 1'b0;
        if (!stop) begin
            if (r_cm == '0) begin
                if ((r_c1 == '0) || (r_c2 == '0)) begin
                    emit_dec = 1'b1;
                end else begin
                    push_dec = 1'b1;
                end
            end else if (((r_c1 & r_cm) == '0) && ((r_c2 & r_cm) == '0)) begin
                push_dec = 1'b1;
            end
        end
    end

    assign push_en = (r_state == ST_DECIDE) && push_dec && can_push;

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_n          <= '0;
            r_ov         <= 1'b0;
            r_held_v     <= 1'b0;
            r_done_after <= 1'b0;
            r_left       <= '0;
            r_right      <= '1;
            r_bottom     <= '0;
            r_top        <= '1;
        end else begin
            // Raise valid on a new result, drop it once the transaction is taken
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (cfg_wr) begin
                case (paddr[3:2])
                    mlc_pkg::REG_WINDOW_LEFT:   r_left   <= pwdata[CB-1:0];
                    mlc_pkg::REG_WINDOW_RIGHT:  r_right  <= pwdata[CB-1:0];
                    mlc_pkg::REG_WINDOW_BOTTOM: r_bottom <= pwdata[CB-1:0];
                    mlc_pkg::REG_WINDOW_TOP:    r_top    <= pwdata[CB-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state  <= ST_ORDER;
                        r_cnt    <= '0;
                        r_n      <= '0;
                        r_held_v <= 1'b0;
                    end
                end
                ST_ORDER: r_state <= ST_CODEA;
                ST_CODEA: r_state <= ST_CODEB;
                ST_CODEB: r_state <= ST_MID;
                ST_MID: begin
                    if ((r_c1 & r_c2) != '0) begin
                        r_state <= ST_NEXT;
                    end else if ((r_c1 | r_c2) == '0) begin
                        r_done_after <= 1'b1;
                        r_state      <= ST_EMIT;
                    end else begin
                        r_state <= ST_CODEM;
                    end
                end
                ST_CODEM: r_state <= ST_DECIDE;
                ST_DECIDE: begin
                    if (stop) begin
                        r_state <= ST_NEXT;
                    end else if (emit_dec) begin
                        r_done_after <= 1'b0;
                        r_state      <= ST_EMIT;
                    end else begin
                        if (push_en) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        r_state <= ST_ORDER;
                    end
                end
                ST_EMIT: begin
                    // Move the previous piece out before holding the new one
                    if (!r_held_v || out_free) begin
                        r_held_v <= 1'b1;
                        r_n      <= r_n + NB'(1);
                        if (r_n == NB'(mlc_pkg::MAX_RESULTS - 1)) begin
                            r_state <= ST_FINISH;
                        end else if (r_done_after) begin
                            r_state <= ST_NEXT;
                        end else begin
                            r_state <= ST_ORDER;
                        end
                    end
                end
                ST_NEXT: begin
                    if (r_cnt != '0) begin
                        r_cnt   <= pop_cnt;
                        r_state <= ST_ORDER;
                    end else begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_held_v <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_seg <= '{ax: i_in_data.start_x, ay: i_in_data.start_y,
                               bx: i_in_data.end_x,   by: i_in_data.end_y};
                end
            end
            ST_ORDER: begin
                if (r_seg.ax > r_seg.bx) begin
                    r_seg <= swapped;
                end
            end
            ST_CODEA: r_c1 <= code_q;
            ST_CODEB: r_c2 <= code_q;
            ST_MID: begin
                r_tx <= sum_x[CB:1];
                r_ty <= sum_y[CB:1];
                r_pc <= r_seg;
            end
            ST_CODEM: r_cm <= code_q;
            ST_DECIDE: begin
                if (!stop) begin
                    if (r_cm == '0) begin
                        if (r_c1 == '0) begin
                            r_pc  <= seg_lo;
                            r_seg <= seg_hi;
                        end else if (r_c2 == '0) begin
                            r_pc  <= '{ax: r_seg.bx, ay: r_seg.by, bx: r_tx, by: r_ty};
                            r_seg <= seg_lo;
                        end else begin
                            r_seg <= seg_lo;
                        end
                    end else if ((r_c1 & r_cm) != '0) begin
                        r_seg <= seg_hi;
                    end else begin
                        r_seg <= seg_lo;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_held_v || out_free) begin
                    if (r_held_v) begin
                        r_out <= '{visible: 1'b1, piece_ax: r_held.ax, piece_ay: r_held.ay,
                                   piece_bx: r_held.bx, piece_by: r_held.by, last: 1'b0};
                    end
                    r_held <= r_pc;
                end
            end
            ST_NEXT: begin
                if (r_cnt != '0) begin
                    r_seg <= r_stack[pop_cnt[SW-1:0]];
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    if (r_held_v) begin
                        r_out <= '{visible: 1'b1, piece_ax: r_held.ax, piece_ay: r_held.ay,
                                   piece_bx: r_held.bx, piece_by: r_held.by, last: 1'b1};
                    end else begin
                        r_out <= '{visible: 1'b0, piece_ax: '0, piece_ay: '0,
                                   piece_bx: '0, piece_by: '0, last: 1'b1};
                    end
                end
            end
            default: ;
        endcase
    end

    // Pending-half stack; a full stack drops the half
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_stack[r_cnt[SW-1:0]] <= seg_hi;
        end
    end

    // Register read-back
    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            mlc_pkg::REG_WINDOW_LEFT:   prdata[CB-1:0] = r_left;
            mlc_pkg::REG_WINDOW_RIGHT:  prdata[CB-1:0] = r_right;
            mlc_pkg::REG_WINDOW_BOTTOM: prdata[CB-1:0] = r_bottom;
            mlc_pkg::REG_WINDOW_TOP:    prdata[CB-1:0] = r_top;
            default: prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Piece count stays within the result limit
    a_n_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NB'(mlc_pkg::MAX_RESULTS))
        else $error("piece count above result limit");

    // Stack never holds more than its depth
    a_stack_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    // An empty result carries zero coordinates and closes the segment
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.visible) |->
            (o_out_data.last && (o_out_data.piece_ax == '0) && (o_out_data.piece_ay == '0) &&
             (o_out_data.piece_bx == '0) && (o_out_data.piece_by == '0)))
        else $error("empty result malformed");

    // An accepted transaction starts work at once
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && (r_state == ST_ORDER)))
        else $error("segment not started after accept");

endmodule
